// ===== hw/rtl/acfb_pkg.sv =====
`default_nettype none

package acfb_pkg;

	// frame constants
	localparam logic [7:0] START_CODE  = 8'hAA;
	localparam logic [7:0] END_CODE    = 8'h55;
	localparam logic [7:0] TEXT_CMD    = 8'h05;
	localparam logic [7:0] CR_CODE     = 8'h0D;
	localparam logic [7:0] LF_CODE     = 8'h0A;
	localparam logic [7:0] NUL_CODE    = 8'h00;
	localparam logic [7:0] MAX_PAYLOAD = 8'd255;

	// header is 11 bytes, trailer is checksum + end, text adds three more
	localparam logic [3:0] HEADER_LEN  = 4'd11;
	localparam logic [3:0] TRAIL_PLAIN = 4'd2;
	localparam logic [3:0] TRAIL_TEXT  = 4'd5;

	localparam logic [7:0] SOURCE_AXIS_RST = 8'hFE;

	// command queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		CFG_TARGET_GROUP = 2'd0,
		CFG_SOURCE_GROUP = 2'd1,
		CFG_SOURCE_AXIS  = 2'd2,
		CFG_RIGHT_GROUP  = 2'd3
	} acfb_cfg_idx_t;

	typedef enum logic {
		REQ_START   = 1'b0,
		REQ_PAYLOAD = 1'b1
	} acfb_req_t;

	typedef struct packed {
		logic [7:0] target_group;
		logic [7:0] source_group;
		logic [7:0] source_axis;
		logic [7:0] right_group;
	} acfb_cfg_t;

	// one classified item as the back end sees it
	typedef struct packed {
		logic       is_start;
		logic       text;
		logic       close;
		logic [8:0] total;
		logic [7:0] msg_id;
		logic [7:0] cmd_type;
		logic [7:0] target_axis;
		logic [7:0] right_axis;
		logic [7:0] data;
	} acfb_cmd_t;

	// queue status toward front and back
	typedef struct packed {
		logic full;
		logic nonempty;
	} acfb_qstat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/acfb_front.sv =====
`default_nettype none

module acfb_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cmd_valid,
	input  wire                  req_type,
	input  wire [7:0]            msg_id,
	input  wire [7:0]            cmd_type,
	input  wire [7:0]            target_axis,
	input  wire [7:0]            right_axis,
	input  wire [7:0]            payload_len,
	input  wire [7:0]            payload_byte,
	input  acfb_pkg::acfb_qstat_t qstat,
	output logic                 push,
	output acfb_pkg::acfb_cmd_t  entry
);
	import acfb_pkg::*;

	logic [7:0] rem_q;
	logic       open_q;
	logic       text_q;

	logic       accept;
	logic       is_start;
	logic [7:0] len_cap;
	logic       text_new;
	logic       pay_close;

	assign accept    = cmd_valid && !qstat.full;
	assign is_start  = (req_type == REQ_START);
	assign len_cap   = (payload_len > MAX_PAYLOAD) ? MAX_PAYLOAD : payload_len;
	assign text_new  = (cmd_type == TEXT_CMD);
	assign pay_close = (rem_q <= 8'd1);

	// payload bytes outside a frame are taken but produce nothing
	assign push = accept && (is_start || open_q);

	always_comb begin
		entry             = '0;
		entry.is_start    = is_start;
		entry.msg_id      = msg_id;
		entry.cmd_type    = cmd_type;
		entry.target_axis = target_axis;
		entry.right_axis  = right_axis;
		entry.data        = payload_byte;
		entry.total       = 9'(HEADER_LEN) + 9'(len_cap)
			+ 9'(text_new ? TRAIL_TEXT : TRAIL_PLAIN);
		if (is_start) begin
			entry.text  = text_new;
			entry.close = (len_cap == 8'd0);
		end else begin
			entry.text  = text_q;
			entry.close = pay_close;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			open_q <= 1'b0;
			text_q <= 1'b0;
		end else if (accept) begin
			if (is_start) begin
				text_q <= text_new;
				rem_q  <= len_cap;
				open_q <= (len_cap != 8'd0);
			end else if (open_q) begin
				if (pay_close) begin
					rem_q  <= '0;
					open_q <= 1'b0;
				end else begin
					rem_q <= rem_q - 8'd1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/acfb_queue.sv =====
`default_nettype none

module acfb_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  acfb_pkg::acfb_cmd_t   push_entry,
	input  wire                   pop,
	output acfb_pkg::acfb_cmd_t   head,
	output acfb_pkg::acfb_qstat_t qstat
);
	import acfb_pkg::*;

	acfb_cmd_t         mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	logic do_push;
	logic do_pop;

	assign qstat.full     = (cnt_q == QCNT_W'(QDEPTH));
	assign qstat.nonempty = (cnt_q != '0);
	assign do_push        = push && !qstat.full;
	assign do_pop         = pop && qstat.nonempty;
	assign head           = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/acfb_back.sv =====
`default_nettype none

module acfb_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  acfb_pkg::acfb_cfg_t   cfg,
	input  acfb_pkg::acfb_qstat_t qstat,
	input  acfb_pkg::acfb_cmd_t   head,
	output logic                  pop,
	output logic                  byte_valid,
	input  wire                   byte_stall,
	output logic [7:0]            out_byte,
	output logic                  run_last,
	output logic                  frame_last
);
	import acfb_pkg::*;

	// header byte offsets
	localparam logic [3:0] H_SYNC  = 4'd0;
	localparam logic [3:0] H_LENHI = 4'd1;
	localparam logic [3:0] H_LENLO = 4'd2;
	localparam logic [3:0] H_TGRP  = 4'd3;
	localparam logic [3:0] H_TAXIS = 4'd4;
	localparam logic [3:0] H_SGRP  = 4'd5;
	localparam logic [3:0] H_SAXIS = 4'd6;
	localparam logic [3:0] H_RGRP  = 4'd7;
	localparam logic [3:0] H_RAXIS = 4'd8;
	localparam logic [3:0] H_MSG   = 4'd9;
	localparam logic [3:0] H_CMD   = 4'd10;

	// trailer slots, plain frames start at the checksum slot
	localparam logic [3:0] T_CR    = 4'd0;
	localparam logic [3:0] T_LF    = 4'd1;
	localparam logic [3:0] T_NUL   = 4'd2;
	localparam logic [3:0] T_CHK   = 4'd3;
	localparam logic [3:0] T_END   = 4'd4;

	logic [3:0] pos_q;
	logic [7:0] xor_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       run_last_q;
	logic       frame_last_q;

	logic       emit;
	logic [3:0] base;
	logic [3:0] last_pos;
	logic       last;
	logic [3:0] tslot;
	logic [7:0] nxt_byte;
	logic       nxt_end;

	assign emit     = qstat.nonempty && (!valid_q || !byte_stall);
	assign base     = head.is_start ? HEADER_LEN : 4'd1;
	assign last_pos = base - 4'd1
		+ (head.close ? (head.text ? TRAIL_TEXT : TRAIL_PLAIN) : 4'd0);
	assign last     = (pos_q == last_pos);
	assign tslot    = head.text ? (pos_q - base) : (pos_q - base + T_CHK);
	assign pop      = emit && last;

	always_comb begin
		nxt_byte = head.data;
		nxt_end  = 1'b0;
		if (pos_q >= base) begin
			case (tslot)
				T_CR:    nxt_byte = CR_CODE;
				T_LF:    nxt_byte = LF_CODE;
				T_NUL:   nxt_byte = NUL_CODE;
				T_CHK:   nxt_byte = xor_q;
				T_END: begin
					nxt_byte = END_CODE;
					nxt_end  = 1'b1;
				end
				default: nxt_byte = END_CODE;
			endcase
		end else if (head.is_start) begin
			case (pos_q)
				H_SYNC:  nxt_byte = START_CODE;
				H_LENHI: nxt_byte = {7'd0, head.total[8]};
				H_LENLO: nxt_byte = head.total[7:0];
				H_TGRP:  nxt_byte = cfg.target_group;
				H_TAXIS: nxt_byte = head.target_axis;
				H_SGRP:  nxt_byte = cfg.source_group;
				H_SAXIS: nxt_byte = cfg.source_axis;
				H_RGRP:  nxt_byte = cfg.right_group;
				H_RAXIS: nxt_byte = head.right_axis;
				H_MSG:   nxt_byte = head.msg_id;
				H_CMD:   nxt_byte = head.cmd_type;
				default: nxt_byte = head.cmd_type;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			xor_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (emit) begin
				pos_q   <= last ? 4'd0 : pos_q + 4'd1;
				xor_q   <= (head.is_start && pos_q == H_SYNC) ? nxt_byte : (xor_q ^ nxt_byte);
				valid_q <= 1'b1;
			end else if (!byte_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q       <= nxt_byte;
			run_last_q   <= last;
			frame_last_q <= nxt_end;
		end
	end

	assign byte_valid = valid_q;
	assign out_byte   = byte_q;
	assign run_last   = run_last_q;
	assign frame_last = frame_last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/axis_command_frame_builder.sv =====
// Servo-axis command frame serializer. Each accepted item is a start request
// (req_type 0), which emits the 11-byte header, or a payload byte (req_type 1),
// which is passed through; the byte that completes payload_len closes the frame
// with CR LF NUL for text commands (cmd_type 5), an XOR checksum over every
// earlier frame byte, and the end byte 0x55 flagged by frame_last. run_last
// marks the final byte caused by each item. Payload bytes outside an open
// frame are taken and dropped; a new start abandons an open frame. Items enter
// a 4-entry command queue, one item per cycle unless it is full; the back-end
// byte sequencer emits one byte per cycle while byte_stall is low. A payload
// byte yields one output byte, a closing one 3 or 6, and a start item 11 bytes
// (up to 16 when the payload is empty). cfg_ready is always high; the user must
// write configuration only while the block is idle, which is not enforced.
`default_nettype none

module axis_command_frame_builder (
	input  wire        clk,
	input  wire        arst_n,

	// item channel
	input  wire        cmd_valid,
	output logic       cmd_stall,
	input  wire        req_type,
	input  wire [7:0]  msg_id,
	input  wire [7:0]  cmd_type,
	input  wire [7:0]  target_axis,
	input  wire [7:0]  right_axis,
	input  wire [7:0]  payload_len,
	input  wire [7:0]  payload_byte,

	// byte channel
	output logic       byte_valid,
	input  wire        byte_stall,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       frame_last,

	// register write channel
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire [1:0]  cfg_index,
	input  wire [7:0]  cfg_data
);
	import acfb_pkg::*;

	acfb_cfg_t   cfg_q;
	acfb_qstat_t qstat;
	acfb_cmd_t   push_entry;
	acfb_cmd_t   head;
	logic        push;
	logic        pop;

	// register writes are always accepted
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_group <= '0;
			cfg_q.source_group <= '0;
			cfg_q.source_axis  <= SOURCE_AXIS_RST;
			cfg_q.right_group  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (acfb_cfg_idx_t'(cfg_index))
				CFG_TARGET_GROUP: cfg_q.target_group <= cfg_data;
				CFG_SOURCE_GROUP: cfg_q.source_group <= cfg_data;
				CFG_SOURCE_AXIS:  cfg_q.source_axis  <= cfg_data;
				CFG_RIGHT_GROUP:  cfg_q.right_group  <= cfg_data;
				default:          cfg_q.right_group  <= cfg_q.right_group;
			endcase
		end
	end

	// front stalls only when the command queue is full
	assign cmd_stall = qstat.full;

	// front: classify items, track payload count and frame state
	acfb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.req_type     (req_type),
		.msg_id       (msg_id),
		.cmd_type     (cmd_type),
		.target_axis  (target_axis),
		.right_axis   (right_axis),
		.payload_len  (payload_len),
		.payload_byte (payload_byte),
		.qstat        (qstat),
		.push         (push),
		.entry        (push_entry)
	);

	// decouples item transfer from byte output
	acfb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	// back: byte sequencer with running checksum and output register
	acfb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.qstat      (qstat),
		.head       (head),
		.pop        (pop),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.frame_last (frame_last)
	);

`ifndef SYNTHESIS
	// closing byte is always the end code and ends the item's run
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && frame_last |-> run_last && out_byte == END_CODE)
		else $error("frame_last without end code or run_last");

	// queue is never written while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("command queue overflow");

	// nothing leaves the queue while the output byte is held
	a_hold_pop: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_stall |-> !pop)
		else $error("queue popped during output stall");

	// a popped entry was present
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> qstat.nonempty)
		else $error("pop from empty command queue");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_axis_command_frame_builder.sv =====
`timescale 1ns / 1ps

module tb_axis_command_frame_builder;
	import acfb_pkg::*;

	// cycles with no transfer on any channel before the run is called hung
	localparam int HANG_LIMIT = 5000;
	// settle time once the byte queue is empty (stray bytes give no output)
	localparam int SETTLE_CYCLES = 32;
	localparam int RANDOM_ITEMS = 100;

	typedef struct {
		acfb_req_t  req;
		logic [7:0] msg;
		logic [7:0] cmd;
		logic [7:0] taxis;
		logic [7:0] raxis;
		logic [7:0] len;
		logic [7:0] data;
	} cmd_item_t;

	typedef struct {
		logic [7:0] value;
		logic       run_last;
		logic       frame_last;
	} frame_byte_t;

	logic       clk;
	logic       arst_n;
	logic       cmd_valid;
	logic       cmd_stall;
	logic       req_type;
	logic [7:0] msg_id;
	logic [7:0] cmd_type;
	logic [7:0] target_axis;
	logic [7:0] right_axis;
	logic [7:0] payload_len;
	logic [7:0] payload_byte;
	logic       byte_valid;
	logic       byte_stall;
	logic [7:0] out_byte;
	logic       run_last;
	logic       frame_last;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	// shadow of the register file and of the framing state
	acfb_cfg_t   cfg_shadow;
	logic [7:0]  pending_bytes;
	logic [7:0]  frame_xor;
	logic        text_frame;
	logic        frame_open;

	// serialized bytes still owed by the block, oldest first
	frame_byte_t byte_q[$];

	int idle_pct;
	int stall_pct;
	int errors;
	int items_done;
	int dropped;
	int frames_started;
	int text_frames;
	int bytes_checked;
	int hang_count;

	axis_command_frame_builder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.req_type     (req_type),
		.msg_id       (msg_id),
		.cmd_type     (cmd_type),
		.target_axis  (target_axis),
		.right_axis   (right_axis),
		.payload_len  (payload_len),
		.payload_byte (payload_byte),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.out_byte     (out_byte),
		.run_last     (run_last),
		.frame_last   (frame_last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// frame prediction
	// ---------------------------------------------------------------

	// every byte sent folds into the running checksum
	function automatic void add_byte(ref frame_byte_t run[$], input logic [7:0] value,
			input logic closing);
		frame_byte_t fb;
		fb.value      = value;
		fb.run_last   = 1'b0;
		fb.frame_last = closing;
		run.push_back(fb);
		frame_xor = frame_xor ^ value;
	endfunction

	// optional CR LF NUL, then checksum over all earlier bytes, then end byte
	function automatic void add_trailer(ref frame_byte_t run[$]);
		if (text_frame) begin
			add_byte(run, CR_CODE, 1'b0);
			add_byte(run, LF_CODE, 1'b0);
			add_byte(run, NUL_CODE, 1'b0);
		end
		add_byte(run, frame_xor, 1'b0);
		add_byte(run, END_CODE, 1'b1);
		frame_open    = 1'b0;
		pending_bytes = 8'd0;
	endfunction

	// appends the bytes one accepted item causes; returns how many
	function automatic int predict_frame_bytes(input cmd_item_t it);
		frame_byte_t run[$];
		logic [7:0]  len;
		logic [15:0] total;
		if (it.req == REQ_START) begin
			len        = (it.len > MAX_PAYLOAD) ? MAX_PAYLOAD : it.len;
			text_frame = (it.cmd == TEXT_CMD);
			total      = 16'(HEADER_LEN) + 16'(len)
				+ (text_frame ? 16'(TRAIL_TEXT) : 16'(TRAIL_PLAIN));
			frame_xor  = 8'h00;
			add_byte(run, START_CODE, 1'b0);
			add_byte(run, total[15:8], 1'b0);
			add_byte(run, total[7:0], 1'b0);
			add_byte(run, cfg_shadow.target_group, 1'b0);
			add_byte(run, it.taxis, 1'b0);
			add_byte(run, cfg_shadow.source_group, 1'b0);
			add_byte(run, cfg_shadow.source_axis, 1'b0);
			add_byte(run, cfg_shadow.right_group, 1'b0);
			add_byte(run, it.raxis, 1'b0);
			add_byte(run, it.msg, 1'b0);
			add_byte(run, it.cmd, 1'b0);
			pending_bytes = len;
			frame_open    = 1'b1;
			if (len == 8'd0)
				add_trailer(run);
		end else if (frame_open) begin
			add_byte(run, it.data, 1'b0);
			if (pending_bytes > 8'd0)
				pending_bytes = pending_bytes - 8'd1;
			if (pending_bytes == 8'd0)
				add_trailer(run);
		end
		if (run.size() > 0)
			run[run.size() - 1].run_last = 1'b1;
		foreach (run[i])
			byte_q.push_back(run[i]);
		return run.size();
	endfunction

	// ---------------------------------------------------------------
	// item construction
	// ---------------------------------------------------------------

	// payload_byte is a don't-care on a start, so it gets noise
	function automatic cmd_item_t start_item(input logic [7:0] msg, cmd, taxis, raxis, len);
		cmd_item_t it;
		it.req   = REQ_START;
		it.msg   = msg;
		it.cmd   = cmd;
		it.taxis = taxis;
		it.raxis = raxis;
		it.len   = len;
		it.data  = 8'($urandom);
		return it;
	endfunction

	// header fields are don't-cares on a payload transfer, so they get noise too
	function automatic cmd_item_t payload_item(input logic [7:0] data);
		cmd_item_t it;
		it.req   = REQ_PAYLOAD;
		it.msg   = 8'($urandom);
		it.cmd   = 8'($urandom);
		it.taxis = 8'($urandom);
		it.raxis = 8'($urandom);
		it.len   = 8'($urandom);
		it.data  = data;
		return it;
	endfunction

	// ---------------------------------------------------------------
	// channel drivers
	// ---------------------------------------------------------------

	// leaves cmd_valid high on return so back-to-back items stream at full rate
	task automatic send_item(input cmd_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid    <= 1'b1;
		req_type     <= it.req;
		msg_id       <= it.msg;
		cmd_type     <= it.cmd;
		target_axis  <= it.taxis;
		right_axis   <= it.raxis;
		payload_len  <= it.len;
		payload_byte <= it.data;
		do @(posedge clk); while (cmd_stall);
		if (predict_frame_bytes(it) > 0) begin
			items_done++;
			if (it.req == REQ_START) begin
				frames_started++;
				if (it.cmd == TEXT_CMD)
					text_frames++;
			end
		end else begin
			dropped++;
		end
	endtask

	// stop sending and wait for every owed byte, then let stray items settle
	task automatic drain();
		cmd_valid <= 1'b0;
		while (byte_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input acfb_cfg_idx_t idx, input logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_TARGET_GROUP: cfg_shadow.target_group = data;
			CFG_SOURCE_GROUP: cfg_shadow.source_group = data;
			CFG_SOURCE_AXIS:  cfg_shadow.source_axis  = data;
			CFG_RIGHT_GROUP:  cfg_shadow.right_group  = data;
			default: ;
		endcase
	endtask

	// registers only change while the block is idle
	task automatic write_config(input logic [7:0] tg, sg, sa, rg);
		drain();
		write_reg(CFG_TARGET_GROUP, tg);
		write_reg(CFG_SOURCE_GROUP, sg);
		write_reg(CFG_SOURCE_AXIS, sa);
		write_reg(CFG_RIGHT_GROUP, rg);
		cfg_valid <= 1'b0;
	endtask

	// ---------------------------------------------------------------
	// byte sink: random stall, in-order check, hang watchdog
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		frame_byte_t want;
		byte_stall <= ($urandom_range(99) < stall_pct);
		if (arst_n && byte_valid && !byte_stall) begin
			bytes_checked++;
			if (byte_q.size() == 0) begin
				$error("unexpected byte transfer: out_byte %h", out_byte);
				errors++;
			end else begin
				want = byte_q.pop_front();
				if (out_byte !== want.value) begin
					$error("out_byte: expected %h, got %h", want.value, out_byte);
					errors++;
				end
				if (run_last !== want.run_last) begin
					$error("run_last: expected %b, got %b", want.run_last, run_last);
					errors++;
				end
				if (frame_last !== want.frame_last) begin
					$error("frame_last: expected %b, got %b", want.frame_last, frame_last);
					errors++;
				end
			end
		end
		// any transfer on any channel counts as progress
		if ((cmd_valid && !cmd_stall) || (byte_valid && !byte_stall)
				|| (cfg_valid && cfg_ready)) begin
			hang_count <= 0;
		end else if (hang_count + 1 >= HANG_LIMIT) begin
			$display("timeout: no transfer for %0d cycles, %0d bytes owed",
				HANG_LIMIT, byte_q.size());
			$display("** axis_command_frame_builder: FAILED **");
			$finish;
		end else begin
			hang_count <= hang_count + 1;
		end
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// header built from reset register values, then a stray byte with no frame
	task automatic test_reset_values();
		send_item(start_item(8'h00, 8'h00, 8'h00, 8'h00, 8'd0));
		send_item(payload_item(8'h3C));
	endtask

	// all-ones and all-zeros registers; text trailer on a one-byte frame
	task automatic test_register_extremes();
		write_config(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_item(start_item(8'hFF, TEXT_CMD, 8'hFF, 8'hFF, 8'd1));
		send_item(payload_item(8'hFF));
		write_config(8'h00, 8'h00, 8'h00, 8'h00);
		send_item(start_item(8'h00, 8'hFF, 8'h00, 8'h00, 8'd2));
		send_item(payload_item(8'h00));
		send_item(payload_item(8'hA5));
	endtask

	// start over an open frame, empty text frame, stray byte after close
	task automatic test_abandoned_frames();
		write_config(8'h12, 8'h34, 8'h56, 8'h78);
		send_item(start_item(8'h01, 8'h04, 8'h10, 8'h20, MAX_PAYLOAD));
		send_item(payload_item(8'h11));
		send_item(payload_item(8'h22));
		send_item(start_item(8'h02, TEXT_CMD, 8'h30, 8'h40, 8'd0));
		send_item(start_item(8'h03, 8'h06, 8'h50, 8'h60, 8'd3));
		send_item(payload_item(8'h33));
		send_item(start_item(8'h04, TEXT_CMD, 8'h70, 8'h80, 8'd1));
		send_item(payload_item(8'h5A));
		send_item(payload_item(8'hC3));
	endtask

	// one text frame at the longest payload, so the length high byte is set
	task automatic test_longest_frame();
		send_item(start_item(8'($urandom), TEXT_CMD, 8'($urandom), 8'($urandom),
			MAX_PAYLOAD));
		repeat (int'(MAX_PAYLOAD))
			send_item(payload_item(8'($urandom)));
	endtask

	// mostly complete frames of small size, some cut short, some stray bytes
	task automatic send_random_frame();
		int         pick;
		int         nsend;
		logic [7:0] len;
		logic [7:0] cmd;
		pick = $urandom_range(99);
		if (pick < 70)
			len = 8'($urandom_range(6));
		else if (pick < 97)
			len = 8'($urandom_range(40, 7));
		else
			len = 8'($urandom_range(80, 41));
		cmd = ($urandom_range(99) < 30) ? TEXT_CMD : 8'($urandom);
		// frames are closed between calls, so these land outside any frame
		if ($urandom_range(99) < 8)
			repeat ($urandom_range(2, 1))
				send_item(payload_item(8'($urandom)));
		send_item(start_item(8'($urandom), cmd, 8'($urandom), 8'($urandom), len));
		nsend = len;
		// a cut-short frame is abandoned by the next start
		if (len > 0 && $urandom_range(99) < 10)
			nsend = $urandom_range(int'(len) - 1);
		repeat (nsend)
			send_item(payload_item(8'($urandom)));
		if (nsend != len)
			send_item(start_item(8'($urandom), cmd, 8'($urandom), 8'($urandom), 8'd0));
	endtask

	task automatic test_random_traffic();
		int goal;
		int next_cfg;
		goal     = items_done + RANDOM_ITEMS;
		next_cfg = items_done + 40;
		while (items_done < goal) begin
			// one long stretch with both sides running flat out
			if (items_done > goal - 80 && items_done < goal - 30) begin
				idle_pct  = 0;
				stall_pct = 0;
			end else begin
				idle_pct  = 19;
				stall_pct = 19;
			end
			// new register values now and then; the drain doubles as a full pause
			if (items_done >= next_cfg) begin
				write_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
				next_cfg = items_done + 40;
			end
			send_random_frame();
		end
		idle_pct  = 19;
		stall_pct = 19;
	endtask

	initial begin
		// every input known from time zero
		arst_n       <= 1'b0;
		cmd_valid    <= 1'b0;
		req_type     <= REQ_START;
		msg_id       <= 8'h00;
		cmd_type     <= 8'h00;
		target_axis  <= 8'h00;
		right_axis   <= 8'h00;
		payload_len  <= 8'h00;
		payload_byte <= 8'h00;
		byte_stall   <= 1'b0;
		cfg_valid    <= 1'b0;
		cfg_index    <= CFG_TARGET_GROUP;
		cfg_data     <= 8'h00;
		hang_count   <= 0;

		// shadow state matches the block after reset
		cfg_shadow.target_group = 8'h00;
		cfg_shadow.source_group = 8'h00;
		cfg_shadow.source_axis  = SOURCE_AXIS_RST;
		cfg_shadow.right_group  = 8'h00;
		pending_bytes  = 8'd0;
		frame_xor      = 8'h00;
		text_frame     = 1'b0;
		frame_open     = 1'b0;
		idle_pct       = 19;
		stall_pct      = 19;
		errors         = 0;
		items_done     = 0;
		dropped        = 0;
		frames_started = 0;
		text_frames    = 0;
		bytes_checked  = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_register_extremes();
		test_abandoned_frames();
		test_random_traffic();
		test_longest_frame();
		drain();

		$display("%0d items (%0d frame starts, %0d text), %0d stray bytes dropped",
			items_done, frames_started, text_frames, dropped);
		$display("%0d serialized bytes checked, %0d mismatches", bytes_checked, errors);
		if (errors == 0)
			$display("** axis_command_frame_builder: PASSED **");
		else
			$display("** axis_command_frame_builder: FAILED **");
		$finish;
	end

endmodule
